@@ src/lr_pkg.sv @@
// Package for the line rasterizer: coordinate width, command, job and pixel types.
// Used by every module of the block; depends on nothing.
package lr_pkg;

  // Width of one coordinate within the tile.
  localparam int unsigned COORD_BITS = 6;
  // Depth of the job queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_BITS = 1;
  localparam int unsigned QUEUE_CNT_BITS = 2;

  // One line command as it arrives.
  typedef struct packed {
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
    logic [31:0]           draw_color;
  } cmd_t;

  // One emitted pixel.
  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [31:0]           pixel_color;
    logic                  last_pixel;
  } pix_t;

  // A classified line, ready to be walked along its major axis.
  typedef struct packed {
    logic [COORD_BITS-1:0]        major_pos;
    logic [COORD_BITS-1:0]        major_end;
    logic [COORD_BITS-1:0]        minor_base;
    logic [COORD_BITS:0]          major_delta;
    logic signed [COORD_BITS:0]   minor_delta;
    logic                         axes_swapped;
    logic [31:0]                  held_color;
  } job_t;

endpackage

@@ src/line_rasterizer.sv @@
// Line rasterizer: one line command in, one pixel per cycle out along the major axis while
// the output is not stalled. A command passes the queue and the walk registers, and its
// first pixel is registered in the output register. In the back end a line takes its setup
// cycle, then the walk; a two-entry queue takes commands ahead while the back end is busy.
// Reset (asynchronous, active low) empties the queue and the output register.
module line_rasterizer import lr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  cmd_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output pix_t out_data_o
);

  job_t front_job;
  job_t queue_job;
  logic queue_full;
  logic queue_empty;
  logic job_pop;

  // Commands wait only while the queue is full.
  assign in_stall_o = queue_full;

  lr_front u_front (
    .cmd_i (in_data_i),
    .job_o (front_job)
  );

  lr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (front_job),
    .full_o      (queue_full),
    .pop_i       (job_pop),
    .pop_data_o  (queue_job),
    .empty_o     (queue_empty)
  );

  lr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_avail_i (!queue_empty),
    .job_i       (queue_job),
    .job_pop_o   (job_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ src/lr_front.sv @@
// Front end of the line rasterizer: swaps steep lines, orders endpoints, forms deltas.
// Depends on lr_pkg.
module lr_front import lr_pkg::*; (
  input  cmd_t cmd_i,
  output job_t job_o
);

  logic [COORD_BITS-1:0] adx, ady;
  logic                  swap;
  logic [COORD_BITS-1:0] maj_a, min_a, maj_b, min_b;
  logic [COORD_BITS-1:0] maj_lo, min_lo, maj_hi, min_hi;

  // Absolute spans decide which axis is the major one.
  always_comb begin
    adx = (cmd_i.start_x > cmd_i.end_x) ? (cmd_i.start_x - cmd_i.end_x)
                                        : (cmd_i.end_x - cmd_i.start_x);
    ady = (cmd_i.start_y > cmd_i.end_y) ? (cmd_i.start_y - cmd_i.end_y)
                                        : (cmd_i.end_y - cmd_i.start_y);
    swap = (adx < ady);
  end

  // Map the endpoints onto major and minor axes.
  always_comb begin
    if (swap) begin
      maj_a = cmd_i.start_y;
      min_a = cmd_i.start_x;
      maj_b = cmd_i.end_y;
      min_b = cmd_i.end_x;
    end else begin
      maj_a = cmd_i.start_x;
      min_a = cmd_i.start_y;
      maj_b = cmd_i.end_x;
      min_b = cmd_i.end_y;
    end
  end

  // Order the endpoints so that the walk runs upward along the major axis.
  always_comb begin
    if (maj_a > maj_b) begin
      maj_lo = maj_b;
      min_lo = min_b;
      maj_hi = maj_a;
      min_hi = min_a;
    end else begin
      maj_lo = maj_a;
      min_lo = min_a;
      maj_hi = maj_b;
      min_hi = min_b;
    end
  end

  // Assemble the job for the back end.
  always_comb begin
    job_o.major_pos    = maj_lo;
    job_o.major_end    = maj_hi;
    job_o.minor_base   = min_lo;
    job_o.major_delta  = {1'b0, maj_hi} - {1'b0, maj_lo};
    job_o.minor_delta  = $signed({1'b0, min_hi} - {1'b0, min_lo});
    job_o.axes_swapped = swap;
    job_o.held_color   = cmd_i.draw_color;
  end

endmodule

@@ src/lr_queue.sv @@
// Short job queue that decouples the front end from the back end.
// Depends on lr_pkg.
module lr_queue import lr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output job_t pop_data_o,
  output logic empty_o
);

  job_t                      mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_BITS-1:0] count_q, count_d;
  logic                      do_push, do_pop;

  assign full_o     = (count_q == QUEUE_CNT_BITS'(QUEUE_DEPTH));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ src/lr_back.sv @@
// Back end of the line rasterizer: walks the major axis and emits one pixel per cycle while the output is not stalled.
// The minor coordinate follows an exact floored quotient kept as quotient and remainder.
// Depends on lr_pkg.
module lr_back import lr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic job_avail_i,
  input  job_t job_i,
  output logic job_pop_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output pix_t out_data_o
);

  logic                          busy_q, busy_d;
  logic [COORD_BITS-1:0]         pos_q, pos_d;
  logic [COORD_BITS-1:0]         end_q, end_d;
  logic [COORD_BITS-1:0]         minor_q, minor_d;
  logic signed [COORD_BITS+1:0]  rem_q, rem_d;
  logic signed [COORD_BITS:0]    ndelta_q, ndelta_d;
  logic [COORD_BITS:0]           mdelta_q, mdelta_d;
  logic                          swap_q, swap_d;
  logic [31:0]                   color_q, color_d;
  logic                          out_valid_q, out_valid_d;
  pix_t                          out_q, out_d;

  logic                          out_free;
  logic                          emit;
  logic                          is_last;
  logic signed [COORD_BITS+1:0]  rem_sum;
  logic signed [COORD_BITS+1:0]  mdelta_s;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign emit        = busy_q && out_free;
  assign is_last     = (pos_q == end_q);
  assign job_pop_o   = !busy_q && job_avail_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Remainder step: add the minor span, then fold back into [0, major span).
  assign rem_sum  = rem_q + {ndelta_q[COORD_BITS], ndelta_q};
  assign mdelta_s = $signed({1'b0, mdelta_q});

  always_comb begin
    busy_d      = busy_q;
    pos_d       = pos_q;
    end_d       = end_q;
    minor_d     = minor_q;
    rem_d       = rem_q;
    ndelta_d    = ndelta_q;
    mdelta_d    = mdelta_q;
    swap_d      = swap_q;
    color_d     = color_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    if (job_pop_o) begin
      // Setup cycle: load the next job from the queue.
      busy_d   = 1'b1;
      pos_d    = job_i.major_pos;
      end_d    = job_i.major_end;
      minor_d  = job_i.minor_base;
      rem_d    = '0;
      ndelta_d = job_i.minor_delta;
      mdelta_d = job_i.major_delta;
      swap_d   = job_i.axes_swapped;
      color_d  = job_i.held_color;
    end else if (emit) begin
      // Emit the current pixel, swapping the axes back where needed.
      out_valid_d       = 1'b1;
      out_d.pixel_x     = swap_q ? minor_q : pos_q;
      out_d.pixel_y     = swap_q ? pos_q : minor_q;
      out_d.pixel_color = color_q;
      out_d.last_pixel  = is_last;
      pos_d             = pos_q + 1'b1;
      if (is_last) begin
        busy_d = 1'b0;
      end
      if (rem_sum >= mdelta_s && mdelta_q != '0) begin
        rem_d   = rem_sum - mdelta_s;
        minor_d = minor_q + 1'b1;
      end else if (rem_sum < 0) begin
        rem_d   = rem_sum + mdelta_s;
        minor_d = minor_q - 1'b1;
      end else begin
        rem_d = rem_sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Walk and payload registers need no reset.
  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    end_q    <= end_d;
    minor_q  <= minor_d;
    rem_q    <= rem_d;
    ndelta_q <= ndelta_d;
    mdelta_q <= mdelta_d;
    swap_q   <= swap_d;
    color_q  <= color_d;
    out_q    <= out_d;
  end

endmodule

@@ src/lr_checker.sv @@
// Port-level checker for the line rasterizer, bound to the top level.
// Depends on lr_pkg.
module lr_checker import lr_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input cmd_t in_data_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input pix_t out_data_o
);

  logic out_xfer;
  logic mid_xfer;

  assign out_xfer = out_valid_o && !out_stall_i;
  assign mid_xfer = out_xfer && !out_data_o.last_pixel;

  // A stalled command holds its payload until its transfer.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled command changed");

  // A stalled pixel holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled pixel changed");

  // Within a line, the next pixel follows in the very next cycle.
  a_line_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_xfer |=> out_valid_o)
    else $error("gap inside a line");

  // Within a line, the color does not change.
  a_line_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_xfer |=> out_data_o.pixel_color == $past(out_data_o.pixel_color))
    else $error("color changed inside a line");

  // Neighboring pixels of a line touch: each coordinate moves by at most one.
  a_line_adjacent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_xfer |=>
      ((out_data_o.pixel_x == $past(out_data_o.pixel_x)) ||
       (out_data_o.pixel_x == $past(out_data_o.pixel_x) + 1'b1) ||
       (out_data_o.pixel_x == $past(out_data_o.pixel_x) - 1'b1)) &&
      ((out_data_o.pixel_y == $past(out_data_o.pixel_y)) ||
       (out_data_o.pixel_y == $past(out_data_o.pixel_y) + 1'b1) ||
       (out_data_o.pixel_y == $past(out_data_o.pixel_y) - 1'b1)))
    else $error("pixels of a line do not touch");

endmodule

bind line_rasterizer lr_checker u_lr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
